// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the classifier modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define PCC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ----- sv/pcc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcc_pkg
// shared types, constants and helpers of the polygon convexity classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcc_pkg;

  // port field widths
  localparam int unsigned VX_WIDTH    = 16;
  localparam int unsigned CLASS_WIDTH = 3;

  // coordinate width used for the geometry, equal to the port field width
  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned DIFF_W      = COORD_BITS + 1;
  localparam int unsigned PROD_W      = 2 * DIFF_W;
  localparam int unsigned CROSS_W     = PROD_W + 1;

  // at most three triples are checked for one vertex (own plus two closing)
  localparam int unsigned NUM_TRIPLES = 3;

  typedef logic signed [1:0] sign_t;
  localparam sign_t SIGN_NEG  = 2'sb11;
  localparam sign_t SIGN_ZERO = 2'sb00;
  localparam sign_t SIGN_POS  = 2'sb01;

  localparam logic [1:0] DCHG_MAX = 2'd3;
  localparam logic [1:0] DCHG_LIM = 2'd2;

  typedef enum logic [1:0] {
    SEEN_NONE = 2'd0,
    SEEN_ONE  = 2'd1,
    SEEN_MANY = 2'd2
  } seen_e;

  typedef enum logic [CLASS_WIDTH-1:0] {
    CLS_NOT_CONVEX       = 3'd0,
    CLS_NOT_CONVEX_DEGEN = 3'd1,
    CLS_CONVEX_DEGEN     = 3'd2,
    CLS_CONVEX_CCW       = 3'd3,
    CLS_CONVEX_CW        = 3'd4
  } shape_class_e;

  typedef logic signed [VX_WIDTH-1:0]   field_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic   valid;
    field_t vx;
    field_t vy;
    logic   closing;
  } vtx_reg_t;

  typedef struct packed {
    logic   vld;
    point_t p;
    point_t q;
    point_t r;
  } triple_t;

  // tracker to cross-product stage
  typedef struct packed {
    logic                            valid;
    logic                            closing;
    logic                            few;
    logic [1:0]                      dchg;
    triple_t [NUM_TRIPLES-1:0]       trip;
  } stage1_t;

  // cross-product stage to classifier
  typedef struct packed {
    logic                            valid;
    logic                            closing;
    logic                            few;
    logic [1:0]                      dchg;
    logic [NUM_TRIPLES-1:0]          tvld;
    logic [NUM_TRIPLES-1:0][PROD_W-1:0] prod_a;
    logic [NUM_TRIPLES-1:0][PROD_W-1:0] prod_b;
  } stage2_t;

  // lexicographic order of two points, x first then y
  function automatic sign_t lex_cmp(point_t a, point_t b);
    sign_t res;
    if ($signed(a.x) < $signed(b.x)) begin
      res = SIGN_NEG;
    end else if ($signed(a.x) > $signed(b.x)) begin
      res = SIGN_POS;
    end else if ($signed(a.y) < $signed(b.y)) begin
      res = SIGN_NEG;
    end else if ($signed(a.y) > $signed(b.y)) begin
      res = SIGN_POS;
    end else begin
      res = SIGN_ZERO;
    end
    return res;
  endfunction

endpackage

// ----- sv/pcc_vertex_if.sv -----
// ----------------------------------------------------------------------------
// pcc_vertex_if
// vertex channel: valid/ready with x, y and the closing flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcc_vertex_if;
  import pcc_pkg::*;

  logic                valid;
  logic                ready;
  logic [VX_WIDTH-1:0] vx;
  logic [VX_WIDTH-1:0] vy;
  logic                final_vertex;

  modport source (output valid, output vx, output vy, output final_vertex, input ready);
  modport sink   (input valid, input vx, input vy, input final_vertex, output ready);
endinterface

// ----- sv/pcc_class_if.sv -----
// ----------------------------------------------------------------------------
// pcc_class_if
// result channel: valid/ready with the shape class
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcc_class_if;
  import pcc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CLASS_WIDTH-1:0] shape_class;

  modport source (output valid, output shape_class, input ready);
  modport sink   (input valid, input shape_class, output ready);
endinterface

// ----- sv/polygon_convexity_classifier_top.sv -----
// ----------------------------------------------------------------------------
// polygon_convexity_classifier_top
// path: the closing vertex goes through the input, tracker, cross-product and result registers
// throughput: one vertex per cycle; all stages hold only while a result waits
// reset: rst_ni clears the vertex history, turn state and all valid flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polygon_convexity_classifier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcc_vertex_if.sink  vtx_i,
  pcc_class_if.source cls_o
);
  import pcc_pkg::*;

  logic    adv;
  stage1_t s1;
  stage2_t s2;

  pcc_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx_i),
    .adv_i  (adv),
    .s1_o   (s1)
  );

  pcc_cross u_cross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .s1_i   (s1),
    .s2_o   (s2)
  );

  pcc_classify u_classify (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s2_i   (s2),
    .cls_o  (cls_o),
    .adv_o  (adv)
  );

endmodule

// ----- sv/pcc_track.sv -----
// ----------------------------------------------------------------------------
// pcc_track
// input register, distinct vertex tracking and direction change counting;
// builds the triples to be checked for each item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcc_track (
  input  logic             clk_i,
  input  logic             rst_ni,
  pcc_vertex_if.sink       vtx_i,
  input  logic             adv_i,
  output pcc_pkg::stage1_t s1_o
);
  import pcc_pkg::*;

  vtx_reg_t in_q;
  point_t   older_q, newer_q, start_q, second_q;
  point_t   older_d, newer_d, start_d, second_d;
  seen_e    seen_q, seen_d;
  sign_t    cur_dir_q, cur_dir_d;
  logic [1:0] dchg_q, dchg_d;
  stage1_t  s1_q, s1_d;

  point_t   pt, o, n, st, sc;
  seen_e    seen;
  sign_t    cd;
  logic [1:0] dc;
  sign_t    cmp_op, cmp_np, cmp_ns, cmp_nsc;
  sign_t    dir [NUM_TRIPLES];
  triple_t [NUM_TRIPLES-1:0] trip;

  assign vtx_i.ready = adv_i;
  assign s1_o        = s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (adv_i) begin
      in_q.valid   <= vtx_i.valid;
      in_q.vx      <= field_t'(vtx_i.vx);
      in_q.vy      <= field_t'(vtx_i.vy);
      in_q.closing <= vtx_i.final_vertex;
    end
  end

  always_comb begin
    pt.x = coord_t'($unsigned(in_q.vx));
    pt.y = coord_t'($unsigned(in_q.vy));
    o    = older_q;
    n    = newer_q;
    st   = start_q;
    sc   = second_q;
    seen = seen_q;
    cd   = cur_dir_q;
    dc   = dchg_q;
    trip = '0;
    for (int i = 0; i < NUM_TRIPLES; i++) begin
      dir[i] = SIGN_ZERO;
    end

    cmp_op = lex_cmp(older_q, pt);
    cmp_np = lex_cmp(newer_q, pt);

    unique case (seen_q)
      SEEN_NONE: begin
        st   = pt;
        o    = pt;
        seen = SEEN_ONE;
      end
      SEEN_ONE: begin
        if (cmp_op != SIGN_ZERO) begin
          n    = pt;
          sc   = pt;
          cd   = cmp_op;
          seen = SEEN_MANY;
        end
      end
      default: begin
        if (cmp_np != SIGN_ZERO) begin
          trip[0] = '{vld: 1'b1, p: o, q: n, r: pt};
          dir[0]  = cmp_np;
          o       = n;
          n       = pt;
        end
      end
    endcase

    // closing triples back to the first two distinct vertices
    cmp_ns = lex_cmp(n, st);
    if (in_q.closing && seen == SEEN_MANY) begin
      if (cmp_ns != SIGN_ZERO) begin
        trip[1] = '{vld: 1'b1, p: o, q: n, r: st};
        dir[1]  = cmp_ns;
        o       = n;
        n       = st;
      end
    end
    cmp_nsc = lex_cmp(n, sc);
    if (in_q.closing && seen == SEEN_MANY) begin
      trip[2] = '{vld: 1'b1, p: o, q: n, r: sc};
      dir[2]  = cmp_nsc;
    end

    // a reversal of step direction bumps the saturating count
    for (int i = 0; i < NUM_TRIPLES; i++) begin
      if (trip[i].vld) begin
        if (dir[i] == -cd && dc != DCHG_MAX) begin
          dc = dc + 2'd1;
        end
        cd = dir[i];
      end
    end

    s1_d.valid   = in_q.valid;
    s1_d.closing = in_q.closing;
    s1_d.few     = (seen != SEEN_MANY);
    s1_d.dchg    = dc;
    s1_d.trip    = trip;

    if (in_q.closing) begin
      older_d   = '0;
      newer_d   = '0;
      start_d   = '0;
      second_d  = '0;
      seen_d    = SEEN_NONE;
      cur_dir_d = SIGN_ZERO;
      dchg_d    = '0;
    end else begin
      older_d   = o;
      newer_d   = n;
      start_d   = st;
      second_d  = sc;
      seen_d    = seen;
      cur_dir_d = cd;
      dchg_d    = dc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q   <= '0;
      newer_q   <= '0;
      start_q   <= '0;
      second_q  <= '0;
      seen_q    <= SEEN_NONE;
      cur_dir_q <= SIGN_ZERO;
      dchg_q    <= '0;
      s1_q      <= '0;
    end else if (adv_i) begin
      if (in_q.valid) begin
        older_q   <= older_d;
        newer_q   <= newer_d;
        start_q   <= start_d;
        second_q  <= second_d;
        seen_q    <= seen_d;
        cur_dir_q <= cur_dir_d;
        dchg_q    <= dchg_d;
      end
      s1_q <= s1_d;
    end
  end

  `PCC_ASSERT(a_state_cleared_after_close, (adv_i && in_q.valid && in_q.closing) |=> (seen_q == SEEN_NONE && dchg_q == 2'd0), "tracker state not cleared after closing vertex")
  `PCC_ASSERT(a_dir_known_when_many, (seen_q == SEEN_MANY) |-> (cur_dir_q != SIGN_ZERO), "no step direction with two distinct vertices")
  `PCC_ASSERT(a_hold_on_stall, !adv_i |=> ($stable(seen_q) && $stable(dchg_q) && $stable(s1_q)), "tracker moved while stalled")

endmodule

// ----- sv/pcc_cross.sv -----
// ----------------------------------------------------------------------------
// pcc_cross
// edge differences and the two products of each triple's cross product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcc_cross (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  pcc_pkg::stage1_t s1_i,
  output pcc_pkg::stage2_t s2_o
);
  import pcc_pkg::*;

  stage2_t s2_q, s2_d;
  diff_t   da [NUM_TRIPLES];
  diff_t   db [NUM_TRIPLES];
  diff_t   dc [NUM_TRIPLES];
  diff_t   dd [NUM_TRIPLES];

  assign s2_o = s2_q;

  always_comb begin
    s2_d.valid   = s1_i.valid;
    s2_d.closing = s1_i.closing;
    s2_d.few     = s1_i.few;
    s2_d.dchg    = s1_i.dchg;
    for (int i = 0; i < NUM_TRIPLES; i++) begin
      // (p-q).x * (q-r).y and (p-q).y * (q-r).x
      da[i] = DIFF_W'($signed(s1_i.trip[i].p.x)) - DIFF_W'($signed(s1_i.trip[i].q.x));
      db[i] = DIFF_W'($signed(s1_i.trip[i].q.y)) - DIFF_W'($signed(s1_i.trip[i].r.y));
      dc[i] = DIFF_W'($signed(s1_i.trip[i].p.y)) - DIFF_W'($signed(s1_i.trip[i].q.y));
      dd[i] = DIFF_W'($signed(s1_i.trip[i].q.x)) - DIFF_W'($signed(s1_i.trip[i].r.x));
      s2_d.tvld[i]   = s1_i.trip[i].vld;
      s2_d.prod_a[i] = PROD_W'(da[i]) * PROD_W'(db[i]);
      s2_d.prod_b[i] = PROD_W'(dc[i]) * PROD_W'(dd[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (adv_i) begin
      s2_q <= s2_d;
    end
  end

endmodule

// ----- sv/pcc_classify.sv -----
// ----------------------------------------------------------------------------
// pcc_classify
// turn sign tracking, concavity latch, class decision and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcc_classify (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pcc_pkg::stage2_t s2_i,
  pcc_class_if.source      cls_o,
  output logic             adv_o
);
  import pcc_pkg::*;

  sign_t        turn_q, turn_d;
  logic         concave_q, concave_d;
  logic         out_valid_q;
  shape_class_e shape_q, shape_d;
  cross_t       v [NUM_TRIPLES];
  sign_t        s [NUM_TRIPLES];
  sign_t        ts;
  logic         cc;

  assign adv_o             = !out_valid_q || cls_o.ready;
  assign cls_o.valid       = out_valid_q;
  assign cls_o.shape_class = shape_q;

  always_comb begin
    ts = turn_q;
    cc = concave_q;
    for (int i = 0; i < NUM_TRIPLES; i++) begin
      v[i] = CROSS_W'($signed(s2_i.prod_a[i])) - CROSS_W'($signed(s2_i.prod_b[i]));
      s[i] = v[i][CROSS_W-1] ? SIGN_NEG : ((v[i] != '0) ? SIGN_POS : SIGN_ZERO);
      // a turn against the remembered sign latches not-convex
      if (s2_i.tvld[i] && s[i] != SIGN_ZERO) begin
        if (ts == -s[i]) begin
          cc = 1'b1;
        end else begin
          ts = s[i];
        end
      end
    end

    priority if (s2_i.few) begin
      shape_d = CLS_CONVEX_DEGEN;
    end else if (cc) begin
      shape_d = CLS_NOT_CONVEX;
    end else if (s2_i.dchg > DCHG_LIM) begin
      shape_d = (ts != SIGN_ZERO) ? CLS_NOT_CONVEX : CLS_NOT_CONVEX_DEGEN;
    end else if (ts == SIGN_POS) begin
      shape_d = CLS_CONVEX_CCW;
    end else if (ts == SIGN_NEG) begin
      shape_d = CLS_CONVEX_CW;
    end else begin
      shape_d = CLS_CONVEX_DEGEN;
    end

    if (s2_i.closing) begin
      turn_d    = SIGN_ZERO;
      concave_d = 1'b0;
    end else begin
      turn_d    = ts;
      concave_d = cc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_q      <= SIGN_ZERO;
      concave_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      if (s2_i.valid) begin
        turn_q    <= turn_d;
        concave_q <= concave_d;
      end
      out_valid_q <= s2_i.valid && s2_i.closing;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      shape_q <= shape_d;
    end
  end

  `PCC_ASSERT_NEVER(a_concave_needs_turn, concave_q && turn_q == SIGN_ZERO, "concavity latched without a turn sign")
  `PCC_ASSERT(a_result_from_close, $rose(out_valid_q) |-> $past(s2_i.valid && s2_i.closing), "result raised without a closing vertex")

endmodule

// ----- verif/tb_polygon_convexity_classifier_top.sv -----
// ----------------------------------------------------------------------------
// tb_polygon_convexity_classifier_top
// self-checking bench: streams polygons vertex by vertex into the classifier,
// predicts the shape class of each closed polygon and compares it with the
// class that comes out, under several sender idle and receiver stall mixes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_polygon_convexity_classifier_top;
  import pcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned NUM_PHASES   = 4;
  localparam int unsigned SRC_IDLE_PCT [NUM_PHASES] = '{0, 78, 0, 27};
  localparam int unsigned SNK_STALL_PCT[NUM_PHASES] = '{0, 0, 78, 27};
  localparam real         TWO_PI       = 6.283185307179586;

  typedef struct packed {
    field_t x;
    field_t y;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pcc_vertex_if vtx ();
  pcc_class_if  cls ();

  polygon_convexity_classifier_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx),
    .cls_o  (cls)
  );

  always #2 clk_i = ~clk_i;

  int unsigned  src_idle_pct;
  int unsigned  snk_stall_pct;
  int unsigned  cycle_count = 0;
  int unsigned  mismatch_count = 0;
  shape_class_e class_q[$];
  vertex_t      outline[$];

  // polygon tracking state of the predictor
  point_t older_pt, newer_pt, first_pt, second_pt;
  seen_e  seen;
  int     heading;
  int     turn_dir;
  int     reversals;
  bit     reflex_seen;

  function automatic longint wide_of(coord_t c);
    return longint'(c);
  endfunction

  function automatic int lex_order(point_t a, point_t b);
    if (wide_of(a.x) < wide_of(b.x)) return -1;
    if (wide_of(a.x) > wide_of(b.x)) return 1;
    if (wide_of(a.y) < wide_of(b.y)) return -1;
    if (wide_of(a.y) > wide_of(b.y)) return 1;
    return 0;
  endfunction

  function automatic int turn_sense(point_t p, point_t q, point_t r);
    longint v;
    v = (wide_of(p.x) - wide_of(q.x)) * (wide_of(q.y) - wide_of(r.y))
      - (wide_of(p.y) - wide_of(q.y)) * (wide_of(q.x) - wide_of(r.x));
    if (v < 0) return -1;
    if (v > 0) return 1;
    return 0;
  endfunction

  function automatic void clear_polygon();
    older_pt    = '0;
    newer_pt    = '0;
    first_pt    = '0;
    second_pt   = '0;
    seen        = SEEN_NONE;
    heading     = 0;
    turn_dir    = 0;
    reversals   = 0;
    reflex_seen = 1'b0;
  endfunction

  // one edge step: direction reversal count and turn sign of the corner
  function automatic void advance_edge(point_t third);
    int d;
    int s;
    d = lex_order(newer_pt, third);
    if (d == -heading && reversals < 3) reversals++;
    heading = d;
    s = turn_sense(older_pt, newer_pt, third);
    if (s != 0) begin
      if (turn_dir == -s) reflex_seen = 1'b1;
      else turn_dir = s;
    end
    older_pt = newer_pt;
    newer_pt = third;
  endfunction

  // returns 1 when the vertex closes a polygon, with its class
  function automatic bit classify_vertex(field_t vx, field_t vy, bit fin,
                                         output shape_class_e shape);
    point_t p;
    p.x   = coord_t'(vx);
    p.y   = coord_t'(vy);
    shape = CLS_CONVEX_DEGEN;
    case (seen)
      SEEN_NONE: begin
        first_pt = p;
        older_pt = p;
        seen     = SEEN_ONE;
      end
      SEEN_ONE: begin
        if (lex_order(older_pt, p) != 0) begin
          newer_pt  = p;
          second_pt = p;
          heading   = lex_order(older_pt, p);
          seen      = SEEN_MANY;
        end
      end
      default: begin
        if (lex_order(newer_pt, p) != 0) advance_edge(p);
      end
    endcase
    if (!fin) return 1'b0;
    if (seen == SEEN_MANY) begin
      if (lex_order(newer_pt, first_pt) != 0) advance_edge(first_pt);
      advance_edge(second_pt);
      if (reflex_seen) shape = CLS_NOT_CONVEX;
      else if (reversals > 2)
        shape = (turn_dir != 0) ? CLS_NOT_CONVEX : CLS_NOT_CONVEX_DEGEN;
      else if (turn_dir > 0) shape = CLS_CONVEX_CCW;
      else if (turn_dir < 0) shape = CLS_CONVEX_CW;
      else shape = CLS_CONVEX_DEGEN;
    end
    clear_polygon();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // result side: random stalls and comparison with the oldest expected class
  always @(posedge clk_i) begin
    shape_class_e want;
    if (rst_ni && cls.valid && cls.ready) begin
      if (class_q.size() == 0) begin
        report_mismatch($sformatf("shape_class %0d with no class expected",
                                  cls.shape_class));
      end else begin
        want = class_q.pop_front();
        if (cls.shape_class !== want)
          report_mismatch($sformatf("shape_class got %0d expected %0d (%s)",
                                    cls.shape_class, want, want.name()));
      end
    end
    cls.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("polygon_convexity_classifier_top regression: fail");
      $finish;
    end
  end

  // valid stays high from one item to the next unless an idle cycle comes
  task automatic send_vertex(input field_t x, input field_t y, input bit fin);
    shape_class_e shape;
    while ($urandom_range(99) < src_idle_pct) begin
      vtx.valid        <= 1'b0;
      vtx.vx           <= field_t'($urandom);
      vtx.vy           <= field_t'($urandom);
      vtx.final_vertex <= 1'($urandom);
      @(posedge clk_i);
    end
    vtx.valid        <= 1'b1;
    vtx.vx           <= x;
    vtx.vy           <= y;
    vtx.final_vertex <= fin;
    do @(posedge clk_i); while (!vtx.ready);
    if (classify_vertex(x, y, fin, shape)) class_q.push_back(shape);
  endtask

  task automatic wait_for_classes();
    vtx.valid <= 1'b0;
    while (class_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic void add_vertex(int x, int y);
    vertex_t v;
    v.x = field_t'(x);
    v.y = field_t'(y);
    outline.push_back(v);
  endfunction

  task automatic send_outline();
    for (int k = 0; k < outline.size(); k++)
      send_vertex(outline[k].x, outline[k].y, k == outline.size() - 1);
    outline.delete();
  endtask

  // points on a circle at angles stepping one way round, sometimes winding twice round
  function automatic void build_convex();
    int  n;
    int  rad;
    int  cx;
    int  cy;
    int  wind;
    real phase0;
    real sense;
    real ang;
    n      = $urandom_range(3, 10);
    rad    = ($urandom_range(3) == 0) ? $urandom_range(2, 40) : $urandom_range(41, 22000);
    cx     = int'($urandom_range(20000)) - 10000;
    cy     = int'($urandom_range(20000)) - 10000;
    wind   = (n >= 5 && n % 2 == 1 && $urandom_range(4) == 0) ? 2 : 1;
    phase0 = TWO_PI * $urandom_range(999) / 1000.0;
    sense  = $urandom_range(1) ? 1.0 : -1.0;
    for (int k = 0; k < n; k++) begin
      ang = phase0 + sense * wind * TWO_PI * (k + 0.8 * $urandom_range(999) / 1000.0) / n;
      add_vertex(cx + int'(rad * $cos(ang)), cy + int'(rad * $sin(ang)));
      if ($urandom_range(9) == 0) outline.push_back(outline[$]);
    end
    if ($urandom_range(3) == 0) outline.push_back(outline[0]);
  endfunction

  // anything goes: full-range points or a tight cluster, with repeats
  function automatic void build_scattered();
    int n;
    int bx;
    int by;
    bit wide;
    n    = $urandom_range(1, 10);
    wide = $urandom_range(1);
    bx   = int'($urandom_range(60000)) - 30000;
    by   = int'($urandom_range(60000)) - 30000;
    for (int k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(4) == 0) outline.push_back(outline[$]);
      else if (wide)
        add_vertex(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768);
      else
        add_vertex(bx + int'($urandom_range(6)) - 3, by + int'($urandom_range(6)) - 3);
    end
  endfunction

  // points on one line, walking back and forth, now and then nudged off it
  function automatic void build_collinear();
    int n;
    int bx;
    int by;
    int dx;
    int dy;
    int t;
    n  = $urandom_range(2, 6);
    bx = int'($urandom_range(40000)) - 20000;
    by = int'($urandom_range(40000)) - 20000;
    dx = int'($urandom_range(200)) - 100;
    dy = int'($urandom_range(200)) - 100;
    if (dx == 0 && dy == 0) dx = 1;
    for (int k = 0; k < n; k++) begin
      t = int'($urandom_range(20)) - 10;
      add_vertex(bx + t * dx, by + t * dy);
    end
    if ($urandom_range(2) == 0) add_vertex(bx + 3 * dx + 1, by + 3 * dy);
  endfunction

  task automatic test_directed_shapes();
    // a lone vertex, then one vertex given twice
    add_vertex(5, 5);
    send_outline();
    add_vertex(7, -3);
    add_vertex(7, -3);
    send_outline();
    // counter-clockwise triangle with a repeated corner
    add_vertex(0, 0);
    add_vertex(10, 0);
    add_vertex(10, 0);
    add_vertex(0, 10);
    send_outline();
    // clockwise triangle closed back onto its start
    add_vertex(0, 0);
    add_vertex(0, 10);
    add_vertex(10, 0);
    add_vertex(0, 0);
    send_outline();
    // dart with one reflex corner
    add_vertex(0, 0);
    add_vertex(10, 5);
    add_vertex(0, 10);
    add_vertex(3, 5);
    send_outline();
    // three points on a line
    add_vertex(0, 0);
    add_vertex(1, 1);
    add_vertex(2, 2);
    send_outline();
    // square on the corners of the coordinate range
    add_vertex(-32768, -32768);
    add_vertex(32767, -32768);
    add_vertex(32767, 32767);
    add_vertex(-32768, 32767);
    send_outline();
    // pentagram: every turn the same way but it winds twice
    add_vertex(100, 0);
    add_vertex(-81, 59);
    add_vertex(31, -95);
    add_vertex(31, 95);
    add_vertex(-81, -59);
    send_outline();
  endtask

  task automatic test_convex_polygons(input int unsigned n_items);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      build_convex();
      sent += outline.size();
      send_outline();
    end
  endtask

  task automatic test_scattered_vertices(input int unsigned n_items);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      build_scattered();
      sent += outline.size();
      send_outline();
    end
  endtask

  task automatic test_collinear_runs(input int unsigned n_items);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      build_collinear();
      sent += outline.size();
      send_outline();
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    vtx.valid        = 1'b0;
    vtx.vx           = '0;
    vtx.vy           = '0;
    vtx.final_vertex = 1'b0;
    cls.ready        = 1'b0;
    src_idle_pct     = 0;
    snk_stall_pct    = 0;
    clear_polygon();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_shapes();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      src_idle_pct  = SRC_IDLE_PCT[ph];
      snk_stall_pct = SNK_STALL_PCT[ph];
      test_convex_polygons(80);
      test_scattered_vertices(30);
      test_collinear_runs(15);
    end
    wait_for_classes();
    if (mismatch_count == 0) begin
      $display("polygon_convexity_classifier_top regression: pass");
    end else begin
      $display("polygon_convexity_classifier_top regression: fail");
    end
    $finish;
  end

endmodule
